// File: design/pctd_pkg.sv
// Shared constants, codes and word types for the prefix code tree decoder.
package pctd_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int MAX_CODE_BITS = 32;
    localparam int SYMBOL_WIDTH  = 10;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = NODE_W + 1;
    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int SYM_IO_W = 10;
    localparam int STAT_W   = 3;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_DECODE = 2'd1,
        ACT_EOS    = 2'd2
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_FOUND       = 3'd0,
        ST_NOT_IN_TREE = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_FULL        = 3'd3,
        ST_EOS         = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_A,
        S_A_STEP,
        S_A_INIT,
        S_LOAD_D,
        S_D_STEP,
        S_D_CHK
    } fsm_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [CODE_W-1:0]   code_bits;
        logic [LEN_W-1:0]    code_length;
        logic [SYM_IO_W-1:0] new_symbol;
        logic                stream_bit;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [SYM_IO_W-1:0] symbol;
        logic [LEN_W-1:0]    bits_used;
    } out_word_t;

    // One tree node as held in the node store.
    typedef struct packed {
        logic [NODE_W-1:0]       left;
        logic [NODE_W-1:0]       right;
        logic                    holds;
        logic [SYMBOL_WIDTH-1:0] sym;
    } node_word_t;

    localparam int WORD_W = $bits(node_word_t);

endpackage

// File: design/pctd_ram.sv
// Generic single write, single read RAM with registered read data.
module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/prefix_code_tree_decoder_top.sv
// Top level of the prefix code tree decoder: command FSM, walk registers, node store.
// Decode word: a cached walk node (every bit of a code after its first) is stepped in the
//   accept cycle then S_D_CHK, else S_LOAD_D, S_D_STEP, S_D_CHK; a missing child ends it.
// Add word: S_LOAD_A reads, S_A_INIT allocates a node, S_A_STEP steps each bit and marks.
// End of stream and empty table words finish in the accept cycle. A result strobes in the
//   cycle after the cycle that decides it; the receiver cannot stall.
// Reset clears control state at once; no clearing pass: nodes are zeroed as allocated.
module prefix_code_tree_decoder_top
    import pctd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  cmd,
    output logic      result_valid,
    output out_word_t result
);

    // Control and walk state
    fsm_t                    state_reg, state_next;
    logic                    table_loaded_reg, table_loaded_next;
    logic                    root_valid_reg, root_valid_next;
    logic                    cache_valid_reg, cache_valid_next;
    logic [FREE_W-1:0]       next_free_reg, next_free_next;
    logic [NODE_W-1:0]       walk_node_reg, walk_node_next;
    logic [LEN_W-1:0]        walk_bits_reg, walk_bits_next;
    logic                    res_valid_reg, res_valid_next;
    logic                    rd_blank_reg;

    // Payload-only registers
    out_word_t               res_reg, res_next;
    node_word_t              node_word_reg, node_word_next;
    logic [NODE_W-1:0]       add_node_reg, add_node_next;
    logic [LEN_W-1:0]        cnt_reg, cnt_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [CODE_W-1:0]       code_reg, code_next;
    logic [SYMBOL_WIDTH-1:0] sym_reg, sym_next;
    logic                    bit_reg, bit_next;

    // Node store port
    logic                    wr_en, rd_en;
    logic [NODE_W-1:0]       wr_addr, rd_addr;
    node_word_t              wr_data;
    logic [WORD_W-1:0]       rd_raw;
    node_word_t              rd_word;

    // Shared decode signals
    logic                    accept;
    logic                    len_ok;
    logic                    step_now;
    logic                    dec_bit;
    logic [NODE_W-1:0]       child;
    logic [LEN_W-1:0]        wb_inc;
    logic                    a_bit;
    logic [NODE_W-1:0]       slot;
    logic                    store_full;
    logic [LEN_W-1:0]        align_shift;
    node_word_t              parent_word;

    pctd_ram #(
        .WIDTH(WORD_W),
        .DEPTH(NODE_COUNT)
    ) u_nodes (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_raw)
    );

    // Root is never allocated, so it reads as empty until first written.
    assign rd_word = rd_blank_reg ? node_word_t'('0) : node_word_t'(rd_raw);

    assign accept      = start && !busy;
    assign len_ok      = (cmd.code_length != '0) && (cmd.code_length <= LEN_W'(MAX_CODE_BITS));
    assign align_shift = LEN_W'(CODE_W) - cmd.code_length;

    // One tree step of decode; taken in the accept cycle when the walk node is cached.
    assign step_now = (state_reg == S_D_STEP) ||
                      (state_reg == S_IDLE && accept && cmd.action == ACT_DECODE &&
                       table_loaded_reg && cache_valid_reg);
    assign dec_bit  = (state_reg == S_IDLE) ? cmd.stream_bit : bit_reg;
    assign child    = dec_bit ? node_word_reg.right : node_word_reg.left;
    assign wb_inc   = walk_bits_reg + LEN_W'(1);

    // Add walk: code is MSB aligned, so the next bit is always the top one.
    assign a_bit      = code_reg[CODE_W-1];
    assign slot       = a_bit ? node_word_reg.right : node_word_reg.left;
    assign store_full = next_free_reg >= FREE_W'(NODE_COUNT);

    always_comb
    begin
        parent_word = node_word_reg;
        if (a_bit)
        begin
            parent_word.right = next_free_reg[NODE_W-1:0];
        end
        else
        begin
            parent_word.left = next_free_reg[NODE_W-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.action)
                        ACT_ADD:
                        begin
                            if (len_ok)
                            begin
                                state_next = S_LOAD_A;
                            end
                        end
                        ACT_DECODE:
                        begin
                            if (table_loaded_reg)
                            begin
                                if (!cache_valid_reg)
                                begin
                                    state_next = S_LOAD_D;
                                end
                                else if (child != '0)
                                begin
                                    state_next = S_D_CHK;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD_A:
            begin
                state_next = S_A_STEP;
            end
            S_A_STEP:
            begin
                if (cnt_reg == len_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (slot == '0)
                begin
                    state_next = store_full ? S_IDLE : S_A_INIT;
                end
                else
                begin
                    state_next = S_LOAD_A;
                end
            end
            S_A_INIT:
            begin
                state_next = S_A_STEP;
            end
            S_LOAD_D:
            begin
                state_next = S_D_STEP;
            end
            S_D_STEP:
            begin
                state_next = (child == '0) ? S_IDLE : S_D_CHK;
            end
            S_D_CHK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, store port and result
    always_comb
    begin
        table_loaded_next = table_loaded_reg;
        cache_valid_next  = cache_valid_reg;
        next_free_next    = next_free_reg;
        walk_node_next    = walk_node_reg;
        walk_bits_next    = walk_bits_reg;
        res_valid_next    = 1'b0;
        res_next          = res_reg;
        node_word_next    = node_word_reg;
        add_node_next     = add_node_reg;
        cnt_next          = cnt_reg;
        len_next          = len_reg;
        code_next         = code_reg;
        sym_next          = sym_reg;
        bit_next          = bit_reg;
        rd_en             = 1'b0;
        rd_addr           = walk_node_reg;
        wr_en             = 1'b0;
        wr_addr           = add_node_reg;
        wr_data           = node_word_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.action)
                        ACT_ADD:
                        begin
                            if (len_ok)
                            begin
                                table_loaded_next = 1'b1;
                                cache_valid_next  = 1'b0;
                                add_node_next     = '0;
                                cnt_next          = '0;
                                len_next          = cmd.code_length;
                                code_next         = cmd.code_bits << align_shift;
                                sym_next          = SYMBOL_WIDTH'(cmd.new_symbol);
                                rd_en             = 1'b1;
                                rd_addr           = '0;
                            end
                        end
                        ACT_DECODE:
                        begin
                            if (!table_loaded_reg)
                            begin
                                res_valid_next = 1'b1;
                                res_next       = '{status: ST_EMPTY, symbol: '0, bits_used: '0};
                            end
                            else
                            begin
                                bit_next = cmd.stream_bit;
                                if (!cache_valid_reg)
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = walk_node_reg;
                                end
                            end
                        end
                        ACT_EOS:
                        begin
                            if (walk_bits_reg != '0)
                            begin
                                res_valid_next   = 1'b1;
                                res_next         = '{status: ST_EOS, symbol: '0,
                                                     bits_used: walk_bits_reg};
                                walk_node_next   = '0;
                                walk_bits_next   = '0;
                                cache_valid_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            S_LOAD_A:
            begin
                node_word_next = rd_word;
            end
            S_A_STEP:
            begin
                if (cnt_reg == len_reg)
                begin
                    // End of code: mark the node, re-adds overwrite the symbol.
                    wr_en         = 1'b1;
                    wr_addr       = add_node_reg;
                    wr_data       = node_word_reg;
                    wr_data.holds = 1'b1;
                    wr_data.sym   = sym_reg;
                end
                else if (slot == '0)
                begin
                    if (store_full)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{status: ST_FULL, symbol: '0, bits_used: cnt_reg};
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = add_node_reg;
                        wr_data        = parent_word;
                        add_node_next  = next_free_reg[NODE_W-1:0];
                        next_free_next = next_free_reg + FREE_W'(1);
                        cnt_next       = cnt_reg + LEN_W'(1);
                        code_next      = code_reg << 1;
                    end
                end
                else
                begin
                    add_node_next = slot;
                    rd_en         = 1'b1;
                    rd_addr       = slot;
                    cnt_next      = cnt_reg + LEN_W'(1);
                    code_next     = code_reg << 1;
                end
            end
            S_A_INIT:
            begin
                // Fresh node: clear its word in the store and in the walk register.
                wr_en          = 1'b1;
                wr_addr        = add_node_reg;
                wr_data        = '0;
                node_word_next = '0;
            end
            S_LOAD_D:
            begin
                node_word_next   = rd_word;
                cache_valid_next = 1'b1;
            end
            S_D_STEP:
            begin
                cache_valid_next = 1'b0;
            end
            S_D_CHK:
            begin
                node_word_next = rd_word;
                if (rd_word.holds)
                begin
                    res_valid_next   = 1'b1;
                    res_next         = '{status: ST_FOUND, symbol: SYM_IO_W'(rd_word.sym),
                                         bits_used: walk_bits_reg};
                    walk_node_next   = '0;
                    walk_bits_next   = '0;
                    cache_valid_next = 1'b0;
                end
                else if (walk_bits_reg >= LEN_W'(MAX_CODE_BITS))
                begin
                    res_valid_next   = 1'b1;
                    res_next         = '{status: ST_NOT_IN_TREE, symbol: '0,
                                         bits_used: walk_bits_reg};
                    walk_node_next   = '0;
                    walk_bits_next   = '0;
                    cache_valid_next = 1'b0;
                end
                else
                begin
                    cache_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase

        if (step_now)
        begin
            if (child == '0)
            begin
                res_valid_next   = 1'b1;
                res_next         = '{status: ST_NOT_IN_TREE, symbol: '0, bits_used: wb_inc};
                walk_node_next   = '0;
                walk_bits_next   = '0;
                cache_valid_next = 1'b0;
            end
            else
            begin
                rd_en            = 1'b1;
                rd_addr          = child;
                walk_node_next   = child;
                walk_bits_next   = wb_inc;
                cache_valid_next = 1'b0;
            end
        end
    end

    assign root_valid_next = root_valid_reg || (wr_en && wr_addr == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            table_loaded_reg <= 1'b0;
            root_valid_reg   <= 1'b0;
            cache_valid_reg  <= 1'b0;
            next_free_reg    <= FREE_W'(1);
            walk_node_reg    <= '0;
            walk_bits_reg    <= '0;
            res_valid_reg    <= 1'b0;
            rd_blank_reg     <= 1'b1;
        end
        else
        begin
            state_reg        <= state_next;
            table_loaded_reg <= table_loaded_next;
            root_valid_reg   <= root_valid_next;
            cache_valid_reg  <= cache_valid_next;
            next_free_reg    <= next_free_next;
            walk_node_reg    <= walk_node_next;
            walk_bits_reg    <= walk_bits_next;
            res_valid_reg    <= res_valid_next;
            if (rd_en)
            begin
                rd_blank_reg <= (rd_addr == '0) && !root_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        node_word_reg <= node_word_next;
        add_node_reg  <= add_node_next;
        cnt_reg       <= cnt_next;
        len_reg       <= len_next;
        code_reg      <= code_next;
        sym_reg       <= sym_next;
        bit_reg       <= bit_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // The walk sits at the root exactly when no bits are pending.
    a_walk_home: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_bits_reg == '0) == (walk_node_reg == '0))
        else $error("walk node and bit count disagree");

    // Allocation pointer never passes the store size nor hands out the root.
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != '0) && (next_free_reg <= FREE_W'(NODE_COUNT)))
        else $error("next free node out of range");

    // The store is only written by the add walk.
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_A_STEP || state_reg == S_A_INIT))
        else $error("node store written outside add walk");

    // Only a found symbol carries a nonzero symbol field.
    a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_FOUND) |-> (result.symbol == '0))
        else $error("symbol field set on a failed result");

    // Empty table reports come from an idle decode with no table and leave the walk home.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_EMPTY) |->
            (!table_loaded_reg && walk_bits_reg == '0 && result.bits_used == '0))
        else $error("empty table report with table loaded");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the prefix code tree decoder: directed and random words against a tree predictor.
module tb_top;
    import pctd_pkg::*;

    // Action code the block must ignore.
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    // Random part length, in words that touch the tree or the walk.
    localparam int RANDOM_WORDS = 1200;
    // New codes are only learned below this node count, so the store lasts
    // until the deliberate fill at the end.
    localparam int NODE_SOFT_CAP = 700;
    // Give trailing results room after the owed results drain.
    localparam int DRAIN_CYCLES = 200;
    localparam int DRAIN_LIMIT  = 20000;

    // Scoreboard: its own copy of the code tree and walk, plus the queue of
    // results the block still owes.
    class tree_scoreboard;
        logic [NODE_W-1:0]       kid_l  [NODE_COUNT];
        logic [NODE_W-1:0]       kid_r  [NODE_COUNT];
        bit                      marked [NODE_COUNT];
        logic [SYMBOL_WIDTH-1:0] sym_at [NODE_COUNT];
        logic [FREE_W-1:0]       next_free;
        bit                      loaded;
        logic [NODE_W-1:0]       walk_at;
        logic [LEN_W-1:0]        walk_depth;
        out_word_t               owed_q[$];
        int                      errors;
        int                      status_seen [5];
        int                      n_add;
        int                      n_decode;
        int                      n_eos;
        int                      n_ignored;

        function new();
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                kid_l[i]  = '0;
                kid_r[i]  = '0;
                marked[i] = 1'b0;
                sym_at[i] = '0;
            end
            for (int i = 0; i < 5; i++)
                status_seen[i] = 0;
            next_free  = 1;
            loaded     = 1'b0;
            walk_at    = '0;
            walk_depth = '0;
            errors     = 0;
            n_add      = 0;
            n_decode   = 0;
            n_eos      = 0;
            n_ignored  = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void owe(status_t st, logic [SYM_IO_W-1:0] sym, logic [LEN_W-1:0] used);
            out_word_t e;
            e.status    = st;
            e.symbol    = sym;
            e.bits_used = used;
            owed_q.push_back(e);
        endfunction

        function void go_root();
            walk_at    = '0;
            walk_depth = '0;
        endfunction

        function void add_code(in_word_t w);
            logic [NODE_W-1:0] node;
            logic [NODE_W-1:0] child;
            int                len;
            logic              b;
            len = int'(w.code_length);
            if (len == 0 || len > MAX_CODE_BITS)
            begin
                n_ignored++;
                return;
            end
            n_add++;
            loaded = 1'b1;
            node   = '0;
            for (int i = 0; i < len; i++)
            begin
                b     = w.code_bits[len-1-i];
                child = b ? kid_r[node] : kid_l[node];
                if (child == '0)
                begin
                    // nodes placed so far stay; no symbol is marked
                    if (next_free >= NODE_COUNT)
                    begin
                        owe(ST_FULL, '0, LEN_W'(i));
                        return;
                    end
                    child = next_free[NODE_W-1:0];
                    next_free++;
                    if (b)
                        kid_r[node] = child;
                    else
                        kid_l[node] = child;
                end
                node = child;
            end
            marked[node] = 1'b1;
            sym_at[node] = w.new_symbol[SYMBOL_WIDTH-1:0];
        endfunction

        function void step_walk(logic b);
            logic [NODE_W-1:0] child;
            if (!loaded)
            begin
                owe(ST_EMPTY, '0, '0);
                return;
            end
            child = b ? kid_r[walk_at] : kid_l[walk_at];
            walk_depth++;
            if (child == '0)
            begin
                owe(ST_NOT_IN_TREE, '0, walk_depth);
                go_root();
                return;
            end
            walk_at = child;
            // a symbol ends the walk even where the node has children
            if (marked[child])
            begin
                owe(ST_FOUND, sym_at[child], walk_depth);
                go_root();
            end
            else if (walk_depth >= MAX_CODE_BITS)
            begin
                owe(ST_NOT_IN_TREE, '0, walk_depth);
                go_root();
            end
        endfunction

        function void note_word(in_word_t w);
            case (w.action)
                ACT_ADD:
                    add_code(w);
                ACT_DECODE:
                begin
                    n_decode++;
                    step_walk(w.stream_bit);
                end
                ACT_EOS:
                begin
                    n_eos++;
                    if (walk_depth != '0)
                        owe(ST_EOS, '0, walk_depth);
                    go_root();
                end
                default:
                    n_ignored++;
            endcase
        endfunction

        function void flag(string field, int unsigned want, int unsigned got);
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        endfunction

        function void check_word(out_word_t r);
            out_word_t e;
            if (r.status <= 3'd4)
                status_seen[int'(r.status)]++;
            if (owed_q.size() == 0)
            begin
                $error("result with nothing owed: status %0d symbol %0d bits_used %0d",
                       r.status, r.symbol, r.bits_used);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (r.status !== e.status)
                flag("status", e.status, r.status);
            if (r.symbol !== e.symbol)
                flag("symbol", e.symbol, r.symbol);
            if (r.bits_used !== e.bits_used)
                flag("bits_used", e.bits_used, r.bits_used);
        endfunction

        function void wrap_up();
            if (owed_q.size() != 0)
            begin
                $error("%0d results never arrived", owed_q.size());
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  cmd;
    logic      result_valid;
    out_word_t result;

    tree_scoreboard sb = new();

    // Codes known to be in the tree, used to build well-formed bit streams.
    logic [CODE_W-1:0] code_tab[$];
    int                len_tab[$];

    bit idle_on;
    int words_done;

    prefix_code_tree_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #(20_000_000);
        $display("prefix_code_tree_decoder_top: mismatch");
        $finish;
    end

    // Results cannot be stalled: every strobed cycle is one word to check.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_word(result);
    end

    // Fields the action does not use carry random junk, so every input bit
    // toggles over the run.
    function automatic in_word_t make_word(logic [1:0] act);
        in_word_t w;
        w.action      = act;
        w.code_bits   = $urandom;
        w.code_length = LEN_W'($urandom);
        w.new_symbol  = SYM_IO_W'($urandom);
        w.stream_bit  = 1'($urandom);
        return w;
    endfunction

    // Hold start until the block takes the word, then draw an idle gap.
    // With no gap, start stays high into the next word.
    task automatic send_word(input in_word_t w);
        int gap;
        cmd   <= w;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_word(w);
        if (w.action != ACT_RESERVED &&
            !(w.action == ACT_ADD &&
              (w.code_length == 0 || w.code_length > MAX_CODE_BITS)))
            words_done++;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_decode(input logic b);
        in_word_t w;
        w            = make_word(ACT_DECODE);
        w.stream_bit = b;
        send_word(w);
    endtask

    task automatic send_eos();
        send_word(make_word(ACT_EOS));
    endtask

    // Only the low len bits of the code matter; the rest stays random.
    task automatic send_add(input logic [CODE_W-1:0] code, input int len,
                            input logic [SYM_IO_W-1:0] sym);
        in_word_t          w;
        logic [CODE_W-1:0] mask;
        w             = make_word(ACT_ADD);
        mask          = (len >= CODE_W) ? '1 : ((32'd1 << len) - 32'd1);
        w.code_bits   = (w.code_bits & ~mask) | (code & mask);
        w.code_length = LEN_W'(len);
        w.new_symbol  = sym;
        send_word(w);
    endtask

    // Length zero or above the maximum: no result, no state change.
    task automatic send_bad_add(input int len);
        in_word_t w;
        w             = make_word(ACT_ADD);
        w.code_length = LEN_W'(len);
        send_word(w);
    endtask

    task automatic learn_code(input logic [CODE_W-1:0] code, input int len,
                              input logic [SYM_IO_W-1:0] sym);
        send_add(code, len, sym);
        code_tab.push_back(code);
        len_tab.push_back(len);
    endtask

    // Stream bits first..first+count-1 of a code, MSB first; optionally
    // invert the code's last bit to fall off the tree.
    task automatic send_code_bits(input logic [CODE_W-1:0] code, input int len,
                                  input int first, input int count, input bit flip_last);
        for (int p = first; p < first + count; p++)
            send_decode(code[len-1-p] ^ (flip_last && p == len - 1));
    endtask

    // Learn a new code while the store has room, else re-add a known one.
    task automatic grow_table();
        int j;
        int len;
        if (sb.next_free < NODE_SOFT_CAP)
        begin
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(3, 10)
                                               : $urandom_range(11, 32);
            learn_code($urandom, len, SYM_IO_W'($urandom));
        end
        else
        begin
            j = $urandom_range(0, code_tab.size() - 1);
            send_add(code_tab[j], len_tab[j], SYM_IO_W'($urandom));
        end
    endtask

    // Sender pause: no new word until every owed result is back.
    task automatic hold_off();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One random group: mostly whole known codes, with noise, broken codes,
    // adds in the middle of a walk and ignored words mixed in.
    task automatic random_group();
        int r;
        int idx;
        int len;
        int k;
        logic [CODE_W-1:0] code;
        r    = $urandom_range(0, 99);
        idx  = $urandom_range(0, code_tab.size() - 1);
        code = code_tab[idx];
        len  = len_tab[idx];
        if (r < 50)
            send_code_bits(code, len, 0, len, 1'b0);
        else if (r < 58)
            send_code_bits(code, len, 0, len, 1'b1);
        else if (r < 66)
            grow_table();
        else if (r < 76)
            repeat ($urandom_range(1, 6)) send_decode(1'($urandom));
        else if (r < 84)
        begin
            k = (len > 1) ? $urandom_range(1, len - 1) : 1;
            send_code_bits(code, len, 0, k, 1'b0);
            send_eos();
        end
        else if (r < 89)
            send_eos();
        else if (r < 93)
            send_word(make_word(ACT_RESERVED));
        else if (r < 97)
            send_bad_add($urandom_range(0, 1) ? 0 : $urandom_range(33, 63));
        else
        begin
            // the walk in progress must survive an add
            k = $urandom_range(1, len);
            send_code_bits(code, len, 0, k, 1'b0);
            grow_table();
            send_code_bits(code, len, k, len - k, 1'b0);
        end
    endtask

    initial
    begin
        int  target;
        int  drain;
        bit  paused;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        idle_on    = 1'b1;
        words_done = 0;
        paused     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: decodes report it, stream end at root is silent, and
        // bad-length adds or reserved words must not load the table.
        send_decode(1'b0);
        send_decode(1'b1);
        send_eos();
        send_bad_add(0);
        send_bad_add(33);
        send_bad_add(63);
        send_word(make_word(ACT_RESERVED));
        send_decode(1'b1);

        // Longest codes down both edges of the tree, a prefix pair, and an
        // overwrite of the shorter code's symbol.
        learn_code(32'hFFFF_FFFF, 32, 10'h3FF);
        learn_code(32'h0000_0000, 32, 10'h000);
        learn_code(32'b0110, 4, 10'h155);
        learn_code(32'b011011, 6, 10'h2AA);
        send_add(32'b0110, 4, 10'h0F0);
        send_code_bits(32'b0110, 4, 0, 4, 1'b0);
        // prefix symbol fires at bit 4, the last two bits start a new walk
        send_code_bits(32'b011011, 6, 0, 6, 1'b0);
        send_eos();
        // falls off the tree at the third bit
        send_code_bits(32'b010, 3, 0, 3, 1'b0);

        // Random part, with one full pause halfway through.
        target = words_done + RANDOM_WORDS;
        while (words_done < target)
        begin
            if ($urandom_range(0, 39) == 0)
                idle_on = !idle_on;
            if (!paused && words_done >= target - RANDOM_WORDS / 2)
            begin
                hold_off();
                paused = 1'b1;
            end
            random_group();
        end

        // Fill the node store, then push adds past its end.
        hold_off();
        while (sb.next_free < NODE_COUNT)
            learn_code($urandom, 32, SYM_IO_W'($urandom));
        repeat (3) send_add($urandom, 32, SYM_IO_W'($urandom));
        send_add($urandom, $urandom_range(2, 31), SYM_IO_W'($urandom));
        // one bit code on an existing node: shadows the whole right half
        learn_code(32'h1, 1, SYM_IO_W'($urandom));
        repeat (60) random_group();

        start <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.wrap_up();

        $display("Covered %0d adds, %0d decode bits, %0d stream ends, %0d ignored words;",
                 sb.n_add, sb.n_decode, sb.n_eos, sb.n_ignored);
        $display("  %0d of %0d nodes used; results: %0d found, %0d not in tree, %0d empty,",
                 sb.next_free, NODE_COUNT, sb.status_seen[0], sb.status_seen[1],
                 sb.status_seen[2]);
        $display("  %0d store full, %0d mid-code ends",
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0)
            $display("prefix_code_tree_decoder_top: match");
        else
            $display("prefix_code_tree_decoder_top: mismatch");
        $finish;
    end

endmodule

// File: prefix_code_tree_decoder_top.f
design/pctd_pkg.sv
design/pctd_ram.sv
design/prefix_code_tree_decoder_top.sv
verif/tb_top.sv
